[rtl/ucsk_pkg.sv]
// shared constants, types and root table for the upward soft-knee compressor
package ucsk_pkg;

  localparam int unsigned CHANNELS = 2;
  localparam int unsigned N_USE    = (CHANNELS < 2) ? CHANNELS : 2;

  localparam int SAMPLE_W   = 24;
  localparam int DB_W       = 18;
  localparam int CFG_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int LOG_MANT_W = 31;
  localparam int FRAC_W     = 16;
  localparam int KW_W       = 17;
  localparam int DIV_NUM_W  = 51;
  localparam int DIV_Q_W    = 17;

  localparam logic signed [DB_W-1:0] LOG_FLOOR_Q8 = -18'sd131072;
  localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394566;
  localparam logic [21:0] OCT_PER_DB_Q24 = 22'd2786635;
  localparam logic [15:0] ONE_Q14        = 16'd16384;
  localparam logic signed [21:0] LOG_OFS = 22'sd1507328;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_RATIO      = 3'd1,
    REG_ATTACK     = 3'd2,
    REG_RELEASE    = 3'd3,
    REG_KNEE_WIDTH = 3'd4,
    REG_KNEE_OFF   = 3'd5,
    REG_PREGAIN    = 3'd6,
    REG_POSTGAIN   = 3'd7
  } cfg_reg_e;

  typedef logic [FRAC_W-1:0][LOG_MANT_W-1:0] root_tbl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem   = n;
    res   = '0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q30 for k = 1..16, by repeated square roots
  function automatic root_tbl_t build_roots();
    root_tbl_t   tbl;
    logic [63:0] t;
    t = isqrt64(64'd1 << 61);
    for (int k = 0; k < FRAC_W; k++) begin
      tbl[k] = t[LOG_MANT_W-1:0];
      t = isqrt64(t << 30);
    end
    return tbl;
  endfunction

  localparam root_tbl_t ROOTS = build_roots();

endpackage

[rtl/ucsk_mul.sv]
// shared signed multiplier with registered product
module ucsk_mul (
  input  logic                                 clk_i,
  input  logic signed [ucsk_pkg::MUL_W-1:0]    a_i,
  input  logic signed [ucsk_pkg::MUL_W-1:0]    b_i,
  output logic signed [ucsk_pkg::PROD_W-1:0]   p_o
);
  import ucsk_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

[rtl/ucsk_div.sv]
// restoring divider for the soft knee, one quotient bit per cycle
module ucsk_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [ucsk_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [ucsk_pkg::KW_W-1:0]          kw_i,
  output logic                               done_o,
  output logic [ucsk_pkg::DIV_Q_W-1:0]       quo_o
);
  import ucsk_pkg::*;

  logic [DIV_NUM_W-1:0] rem_q;
  logic [DIV_NUM_W-1:0] dsh_q;
  logic [DIV_Q_W-1:0]   quo_q;
  logic [4:0]           cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic                 ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(DIV_Q_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  // divisor is kw << 17, first trial shift is 16 more
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= DIV_NUM_W'(kw_i) << (17 + DIV_Q_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[DIV_Q_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/upward_compressor_soft_knee_unit.sv]
// upward soft-knee compressor top level: sequencer around shared multiplier and divider
//
//  port group   dir   handshake                 payload
//  in           in    in_valid_i / in_ready_o   sample_ch0_i, sample_ch1_i
//  out          out   out_valid_o / out_ready_i out_ch0_o, out_ch1_o
//  cfg          in    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// from one accept to the next, the time a word takes depends on its path: bypass, a silent
// mean that skips the log, or the full path; the shared 33x33 multiplier sets it through the
// normalize and squaring steps of the log, a root step of the exponent for each fraction bit,
// the scaling of each channel, and the divider inside the knee.
// rst_ni is asynchronous active low and restores register defaults and zero gain
// a new word is taken while a finished result waits in the output register, and a result
// stalls in the done state while the output register is still full
module upward_compressor_soft_knee_unit #(
  parameter int unsigned CHANNELS = ucsk_pkg::CHANNELS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ucsk_pkg::SAMPLE_W-1:0]  sample_ch0_i,
  input  logic signed [ucsk_pkg::SAMPLE_W-1:0]  sample_ch1_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ucsk_pkg::SAMPLE_W-1:0]  out_ch0_o,
  output logic signed [ucsk_pkg::SAMPLE_W-1:0]  out_ch1_o,
  input  logic                                  cfg_we_i,
  input  logic [ucsk_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ucsk_pkg::CFG_W-1:0]            cfg_data_i
);
  import ucsk_pkg::*;

  localparam int unsigned N_CH = (CHANNELS < 2) ? CHANNELS : 2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NORM, ST_SQ_ISS, ST_SQ_UPD, ST_LVL_ISS, ST_LVL_RND, ST_KNEE,
    ST_LIN_RND, ST_KV1, ST_KV2, ST_KDIV, ST_SM_SEL, ST_SM_M2, ST_SM_ADD, ST_CTL,
    ST_EXP_ISS, ST_EXP_RND, ST_G_ISS, ST_G_UPD, ST_AP_ISS, ST_AP_RND, ST_AP_SHF,
    ST_DONE
  } state_e;

  state_e state_q;

  logic signed [DB_W-1:0] thr_q, pre_q, post_q, gsm_q;
  logic [15:0]            ratio_q, att_q, rel_q;
  logic [KW_W-1:0]        kw_q;
  logic                   koff_q;
  logic                   out_valid_q;
  logic [3:0]             cnt_q;
  logic                   ch_q;

  logic signed [SAMPLE_W-1:0]   s_q [2];
  logic signed [SAMPLE_W-1:0]   res_q [2];
  logic signed [SAMPLE_W-1:0]   out0_q, out1_q;
  logic [LOG_MANT_W-1:0]        y_q;
  logic [4:0]                   p_q;
  logic [FRAC_W-1:0]            frac_q;
  logic signed [18:0]           lvl_q;
  logic [17:0]                  v_q;
  logic signed [DB_W-1:0]       xt_q;
  logic [15:0]                  alpha_q;
  logic signed [35:0]           acc_q;
  logic signed [19:0]           c_q;
  logic signed [10:0]           ip_q;
  logic [FRAC_W-1:0]            f_q;
  logic [LOG_MANT_W-1:0]        g_q;
  logic signed [60:0]           sum_q;
  logic [5:0]                   r_q;

  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]     prod;
  logic                         div_start, div_done;
  logic [DIV_NUM_W-1:0]         div_num;
  logic [DIV_Q_W-1:0]           div_quo;

  logic signed [24:0]           in_sum;
  logic [24:0]                  in_abs;
  logic [SAMPLE_W-1:0]          in_abs0;
  logic [SAMPLE_W-1:0]          in_m;
  logic                         bypass;
  logic [14:0]                  slope;
  logic signed [19:0]           u;
  logic signed [20:0]           u2, kw_s;
  logic                         knee_zero, knee_lin;
  logic [17:0]                  v_w;
  logic [31:0]                  sq;
  logic signed [21:0]           lg;
  logic signed [41:0]           lvl_sum;
  logic signed [DB_W-1:0]       level_w;
  logic signed [35:0]           lin_sum, lin_sh;
  logic signed [DB_W-1:0]       lin_sat;
  logic [15:0]                  alpha_w;
  logic [16:0]                  alpha_c;
  logic signed [36:0]           sm_sum;
  logic signed [DB_W-1:0]       gsm_d;
  logic signed [42:0]           e_sum;
  logic signed [55:0]           ap_prod;
  logic                         ap_special;
  logic signed [SAMPLE_W-1:0]   ap_spec_val;
  logic [5:0]                   r_d;
  logic signed [60:0]           ap_sum, sh;
  logic signed [SAMPLE_W-1:0]   sh_sat;
  logic                         last_ch;
  logic                         out_free;

  ucsk_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ucsk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .kw_i    (kw_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    in_sum  = 25'(sample_ch0_i) + 25'(sample_ch1_i);
    in_abs  = in_sum[24] ? 25'(-in_sum) : 25'(in_sum);
    in_abs0 = sample_ch0_i[SAMPLE_W-1] ? SAMPLE_W'(-sample_ch0_i) : SAMPLE_W'(sample_ch0_i);
    in_m    = (N_CH == 2) ? in_abs[24:1] : in_abs0;
    bypass  = ratio_q >= ONE_Q14;
    slope   = 15'(ONE_Q14 - ratio_q);

    u         = 20'(thr_q) - 20'(lvl_q);
    u2        = {u, 1'b0};
    kw_s      = 21'(kw_q);
    knee_zero = koff_q || (u2 <= -kw_s);
    knee_lin  = u2 >= kw_s;
    v_w       = 18'(u2 + kw_s);

    sq      = prod[61:30];
    lg      = $signed({1'b0, p_q, frac_q}) - LOG_OFS;
    lvl_sum = 42'(prod) + 42'sd8388608;
    level_w = DB_W'(lvl_sum >>> 24);

    lin_sum = 36'(prod) + 36'sd8192;
    lin_sh  = lin_sum >>> 14;
    if (lin_sh > 36'sd131071) begin
      lin_sat = 18'sd131071;
    end else if (lin_sh < -36'sd131072) begin
      lin_sat = -18'sd131072;
    end else begin
      lin_sat = DB_W'(lin_sh);
    end

    alpha_w = (xt_q > gsm_q) ? att_q : rel_q;
    alpha_c = 17'(17'd65536 - 17'(alpha_q));
    sm_sum  = 37'(acc_q) + 37'(prod) + 37'sd32768;
    gsm_d   = DB_W'(sm_sum >>> 16);

    e_sum = 43'(prod) + 43'sd32768;

    ap_prod    = 56'(prod);
    ap_special = (ap_prod == '0) || (ip_q >= 11'sd30) || (ip_q <= -11'sd30);
    if (ap_prod != '0 && ip_q >= 11'sd30) begin
      ap_spec_val = ap_prod[55] ? -24'sd8388608 : 24'sd8388607;
    end else begin
      ap_spec_val = '0;
    end
    r_d    = 6'(11'sd30 - ip_q);
    ap_sum = 61'(ap_prod) + (61'sd1 <<< (r_d - 6'd1));
    sh     = sum_q >>> r_q;
    if (sh > 61'sd8388607) begin
      sh_sat = 24'sd8388607;
    end else if (sh < -61'sd8388608) begin
      sh_sat = -24'sd8388608;
    end else begin
      sh_sat = SAMPLE_W'(sh);
    end

    last_ch   = ch_q == 1'(N_CH - 1);
    out_free  = !out_valid_q || out_ready_i;
    div_start = state_q == ST_KV2;
    div_num   = DIV_NUM_W'(prod[49:0]) + DIV_NUM_W'({kw_q, 16'd0});
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ_ISS: begin
        mul_a = MUL_W'(y_q);
        mul_b = MUL_W'(y_q);
      end
      ST_LVL_ISS: begin
        mul_a = MUL_W'(lg);
        mul_b = MUL_W'(DB_PER_OCT_Q16);
      end
      ST_KNEE: begin
        mul_a = MUL_W'(slope);
        mul_b = knee_lin ? MUL_W'(u) : MUL_W'(v_w);
      end
      ST_KV1: begin
        mul_a = MUL_W'(prod[31:0]);
        mul_b = MUL_W'(v_q);
      end
      ST_SM_SEL: begin
        mul_a = MUL_W'(alpha_w);
        mul_b = MUL_W'(gsm_q);
      end
      ST_SM_M2: begin
        mul_a = MUL_W'(alpha_c);
        mul_b = MUL_W'(xt_q);
      end
      ST_EXP_ISS: begin
        mul_a = MUL_W'(c_q);
        mul_b = MUL_W'(OCT_PER_DB_Q24);
      end
      ST_G_ISS: begin
        mul_a = MUL_W'(g_q);
        mul_b = MUL_W'(ROOTS[cnt_q]);
      end
      ST_AP_ISS: begin
        mul_a = MUL_W'(s_q[ch_q]);
        mul_b = MUL_W'(g_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= -18'sd7680;
      ratio_q     <= 16'd3277;
      att_q       <= '0;
      rel_q       <= '0;
      kw_q        <= 17'd51;
      koff_q      <= 1'b0;
      pre_q       <= '0;
      post_q      <= '0;
      gsm_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ch_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_THRESHOLD:  thr_q   <= $signed(cfg_data_i);
          REG_RATIO:      ratio_q <= cfg_data_i[15:0];
          REG_ATTACK:     att_q   <= cfg_data_i[15:0];
          REG_RELEASE:    rel_q   <= cfg_data_i[15:0];
          REG_KNEE_WIDTH: kw_q    <= cfg_data_i[KW_W-1:0];
          REG_KNEE_OFF:   koff_q  <= cfg_data_i[0];
          REG_PREGAIN:    pre_q   <= $signed(cfg_data_i);
          REG_POSTGAIN:   post_q  <= $signed(cfg_data_i);
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (bypass) begin
              state_q <= ST_EXP_ISS;
            end else if (in_m == '0) begin
              state_q <= ST_KNEE;
            end else begin
              state_q <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (y_q[LOG_MANT_W-1]) begin
            state_q <= ST_SQ_ISS;
            cnt_q   <= '0;
          end
        end
        ST_SQ_ISS: state_q <= ST_SQ_UPD;
        ST_SQ_UPD: begin
          cnt_q   <= cnt_q + 4'd1;
          state_q <= (cnt_q == 4'd15) ? ST_LVL_ISS : ST_SQ_ISS;
        end
        ST_LVL_ISS: state_q <= ST_LVL_RND;
        ST_LVL_RND: state_q <= ST_KNEE;
        ST_KNEE: begin
          if (knee_zero) begin
            state_q <= ST_SM_SEL;
          end else if (knee_lin) begin
            state_q <= ST_LIN_RND;
          end else begin
            state_q <= ST_KV1;
          end
        end
        ST_LIN_RND: state_q <= ST_SM_SEL;
        ST_KV1:     state_q <= ST_KV2;
        ST_KV2:     state_q <= ST_KDIV;
        ST_KDIV: begin
          if (div_done) begin
            state_q <= ST_SM_SEL;
          end
        end
        ST_SM_SEL: begin
          if (alpha_w == '0) begin
            gsm_q   <= xt_q;
            state_q <= ST_CTL;
          end else begin
            state_q <= ST_SM_M2;
          end
        end
        ST_SM_M2: state_q <= ST_SM_ADD;
        ST_SM_ADD: begin
          gsm_q   <= gsm_d;
          state_q <= ST_CTL;
        end
        ST_CTL:     state_q <= ST_EXP_ISS;
        ST_EXP_ISS: state_q <= ST_EXP_RND;
        ST_EXP_RND: begin
          cnt_q   <= '0;
          state_q <= ST_G_ISS;
        end
        ST_G_ISS: begin
          if (f_q[4'd15 - cnt_q]) begin
            state_q <= ST_G_UPD;
          end else if (cnt_q == 4'd15) begin
            ch_q    <= 1'b0;
            state_q <= ST_AP_ISS;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_G_UPD: begin
          if (cnt_q == 4'd15) begin
            ch_q    <= 1'b0;
            state_q <= ST_AP_ISS;
          end else begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= ST_G_ISS;
          end
        end
        ST_AP_ISS: state_q <= ST_AP_RND;
        ST_AP_RND: begin
          if (!ap_special) begin
            state_q <= ST_AP_SHF;
          end else if (last_ch) begin
            state_q <= ST_DONE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= ST_AP_ISS;
          end
        end
        ST_AP_SHF: begin
          if (last_ch) begin
            state_q <= ST_DONE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= ST_AP_ISS;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          s_q[0]   <= sample_ch0_i;
          s_q[1]   <= sample_ch1_i;
          y_q      <= LOG_MANT_W'(in_m) << (LOG_MANT_W - SAMPLE_W);
          p_q      <= 5'(SAMPLE_W - 1);
          frac_q   <= '0;
          lvl_q    <= 19'(LOG_FLOOR_Q8) + 19'(pre_q);
          c_q      <= 20'(post_q);
          res_q[0] <= '0;
          res_q[1] <= '0;
        end
      end
      ST_NORM: begin
        if (!y_q[LOG_MANT_W-1]) begin
          y_q <= y_q << 1;
          p_q <= p_q - 5'd1;
        end
      end
      ST_SQ_UPD: begin
        frac_q <= {frac_q[FRAC_W-2:0], sq[31]};
        y_q    <= sq[31] ? sq[31:1] : sq[30:0];
      end
      ST_LVL_RND: lvl_q <= 19'(level_w) + 19'(pre_q);
      ST_KNEE: begin
        v_q  <= v_w;
        xt_q <= '0;
      end
      ST_LIN_RND: xt_q <= lin_sat;
      ST_KDIV: begin
        if (div_done) begin
          xt_q <= $signed({1'b0, div_quo});
        end
      end
      ST_SM_SEL: alpha_q <= alpha_w;
      ST_SM_M2:  acc_q   <= 36'(prod);
      ST_CTL:    c_q     <= 20'(pre_q) + 20'(post_q) + 20'(gsm_q);
      ST_EXP_RND: begin
        ip_q <= 11'(e_sum >>> 32);
        f_q  <= e_sum[31:16];
        g_q  <= LOG_MANT_W'(1) << 30;
      end
      ST_G_UPD: g_q <= prod[60:30];
      ST_AP_RND: begin
        if (ap_special) begin
          res_q[ch_q] <= ap_spec_val;
        end else begin
          sum_q <= ap_sum;
          r_q   <= r_d;
        end
      end
      ST_AP_SHF: res_q[ch_q] <= sh_sat;
      ST_DONE: begin
        if (out_free) begin
          out0_q <= res_q[0];
          out1_q <= res_q[1];
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_ch0_o   = out0_q;
  assign out_ch1_o   = out1_q;

endmodule

[tb/sv/tb_upward_compressor_soft_knee_unit.sv]
// testbench for the upward soft-knee compressor: directed and random frames and settings, checked by a predictor
module tb_upward_compressor_soft_knee_unit;
  import ucsk_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_ch0_i;
  logic signed [SAMPLE_W-1:0] sample_ch1_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [SAMPLE_W-1:0] out_ch0_o;
  logic signed [SAMPLE_W-1:0] out_ch1_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  upward_compressor_soft_knee_unit dut (.*);

  class gain_scoreboard;
    logic [CFG_W-1:0] regs [8];
    longint gain_db;
    longint unsigned roots [16];
    logic signed [SAMPLE_W-1:0] exp_ch0_q [$];
    logic signed [SAMPLE_W-1:0] exp_ch1_q [$];
    int n_err;
    int n_ok;
    int n_bypass;
    int n_silent;
    int n_sat;

    function new();
      longint unsigned t;
      t = sqrt_floor(64'd1 << 61);
      for (int k = 0; k < 16; k++) begin
        roots[k] = t;
        t = sqrt_floor(t << 30);
      end
      regs[REG_THRESHOLD]  = 18'(-7680);
      regs[REG_RATIO]      = 18'd3277;
      regs[REG_ATTACK]     = '0;
      regs[REG_RELEASE]    = '0;
      regs[REG_KNEE_WIDTH] = 18'd51;
      regs[REG_KNEE_OFF]   = '0;
      regs[REG_PREGAIN]    = '0;
      regs[REG_POSTGAIN]   = '0;
      gain_db = 0;
    endfunction

    function longint unsigned sqrt_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_RATIO, REG_ATTACK, REG_RELEASE: regs[idx] = {2'b0, val[15:0]};
        REG_KNEE_WIDTH: regs[idx] = {1'b0, val[16:0]};
        REG_KNEE_OFF: regs[idx] = {17'b0, val[0]};
        default: regs[idx] = val;
      endcase
    endfunction

    function longint level_q8(longint unsigned m);
      longint unsigned y, frac;
      longint p;
      frac = 0;
      p = 0;
      if (m == 0) return -131072;
      while (p < 23 && (m >> (p + 1)) != 0) p++;
      y = m << (30 - p);
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        frac <<= 1;
        if (y >= (64'd2 << 30)) begin
          frac |= 1;
          y >>= 1;
        end
      end
      return ((((p << 16) | longint'(frac)) - (longint'(23) << 16)) * 394566
              + (longint'(1) << 23)) >>> 24;
    endfunction

    function logic signed [SAMPLE_W-1:0] scale(longint s, longint unsigned g, longint ip);
      longint prod, v;
      int r;
      prod = s * longint'(g);
      if (prod == 0) return '0;
      if (ip >= 30) begin
        n_sat++;
        return prod > 0 ? 24'sh7fffff : 24'sh800000;
      end
      if (30 - ip >= 60) return '0;
      r = int'(30 - ip);
      v = (prod + (longint'(1) << (r - 1))) >>> r;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[SAMPLE_W-1:0];
    endfunction

    function void push_scaled(longint s0, longint s1, longint c);
      longint e, ip;
      longint unsigned f, g;
      e = (c * 2786635 + (longint'(1) << 15)) >>> 16;
      ip = e >>> 16;
      f = e & 64'hffff;
      g = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
        if ((f >> (16 - k)) & 1) g = (g * roots[k-1]) >> 30;
      exp_ch0_q.push_back(scale(s0, g, ip));
      exp_ch1_q.push_back(scale(s1, g, ip));
    endfunction

    function void note_frame(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b);
      longint s0, s1, pre, post, sum, lvl, u, kw, slope, xt, al;
      longint unsigned m, v, den;
      s0 = a;
      s1 = b;
      pre = longint'($signed(regs[REG_PREGAIN]));
      post = longint'($signed(regs[REG_POSTGAIN]));
      if (regs[REG_RATIO] >= 18'(ONE_Q14)) begin
        n_bypass++;
        push_scaled(s0, s1, post);
        return;
      end
      sum = s0 + s1;
      m = longint'(sum < 0 ? -sum : sum) / 2;
      if (m == 0) n_silent++;
      lvl = level_q8(m) + pre;
      u = longint'($signed(regs[REG_THRESHOLD])) - lvl;
      kw = longint'(regs[REG_KNEE_WIDTH]);
      slope = 16384 - longint'(regs[REG_RATIO]);
      if (regs[REG_KNEE_OFF][0] || 2 * u <= -kw) begin
        xt = 0;
      end else if (2 * u >= kw) begin
        xt = (slope * u + (longint'(1) << 13)) >>> 14;
      end else begin
        v = 2 * u + kw;
        den = longint'(kw) << 17;
        xt = longint'((longint'(slope) * v * v + den / 2) / den);
      end
      if (xt > 131071) xt = 131071;
      if (xt < -131072) xt = -131072;
      al = xt > gain_db ? longint'(regs[REG_ATTACK]) : longint'(regs[REG_RELEASE]);
      if (al == 0) gain_db = xt;
      else gain_db = (al * gain_db + (65536 - al) * xt + 32768) >>> 16;
      push_scaled(s0, s1, pre + post + gain_db);
    endfunction

    task report(string what, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
      n_err++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_frame(logic signed [SAMPLE_W-1:0] o0, logic signed [SAMPLE_W-1:0] o1);
      logic signed [SAMPLE_W-1:0] e0, e1;
      if (exp_ch0_q.size() == 0) begin
        report("unexpected word", o0, o1);
        return;
      end
      e0 = exp_ch0_q.pop_front();
      e1 = exp_ch1_q.pop_front();
      if (o0 !== e0) report("out_ch0", o0, e0);
      if (o1 !== e1) report("out_ch1", o1, e1);
      if (o0 === e0 && o1 === e1) n_ok++;
    endtask
  endclass

  gain_scoreboard sb;
  bit calm;
  int n_sent;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #30000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] x;
    case ($urandom_range(0, 5))
      0, 1: x = SAMPLE_W'($urandom);
      2: x = SAMPLE_W'($urandom >> $urandom_range(9, 31));
      3: x = -SAMPLE_W'($urandom >> $urandom_range(9, 31));
      4: x = SAMPLE_W'($urandom >> $urandom_range(17, 31));
      default: begin
        case ($urandom_range(0, 3))
          0: x = 24'h7fffff;
          1: x = 24'h800000;
          2: x = 24'h000001;
          default: x = 24'hffffff;
        endcase
      end
    endcase
    return x;
  endfunction

  always @(negedge clk_i or negedge rst_ni) begin : ready_driver
    int stall;
    if (!rst_ni) begin
      stall = 0;
    end else if (stall > 0) begin
      out_ready_i <= 1'b0;
      stall--;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 25)
        stall = $urandom_range(0, 99) < 90 ? $urandom_range(1, 4) : $urandom_range(20, 90);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_frame(out_ch0_o, out_ch1_o);

  task automatic send_frames(ref logic signed [SAMPLE_W-1:0] ch0 [$],
                             ref logic signed [SAMPLE_W-1:0] ch1 [$]);
    int gap;
    foreach (ch0[i]) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      sample_ch0_i <= ch0[i];
      sample_ch1_i <= ch1[i];
      do @(posedge clk_i); while (!in_ready_o);
      sb.note_frame(ch0[i], ch1[i]);
      n_sent++;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic write_regs(logic [CFG_W-1:0] vals [8]);
    while (sb.exp_ch0_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      sb.set_reg(cfg_reg_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_db(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return CFG_W'($urandom);
      default: return CFG_W'($signed($urandom_range(0, 32000)) - 24000);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] ch0 [$];
    logic signed [SAMPLE_W-1:0] ch1 [$];
    logic [CFG_W-1:0] vals [8];
    sb = new();
    rst_ni = 0;
    in_valid_i = 0;
    out_ready_i = 0;
    sample_ch0_i = '0;
    sample_ch1_i = '0;
    cfg_we_i = 0;
    cfg_idx_i = REG_THRESHOLD;
    cfg_data_i = '0;
    n_sent = 0;
    calm = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 13; ph++) begin
      vals = sb.regs;
      case (ph)
        0: ;
        1: begin
          vals[REG_RATIO] = 18'd65535;
          vals[REG_POSTGAIN] = 18'h1ffff;
        end
        2: begin
          vals[REG_RATIO] = 18'd16384;
          vals[REG_POSTGAIN] = 18'h20000;
        end
        3: begin
          vals = '{18'h1ffff, 18'd0, 18'd65535, 18'd65535, 18'd0, 18'd0, 18'h20000, 18'd0};
        end
        4: begin
          vals = '{18'h20000, 18'd16383, 18'd0, 18'd0, 18'h1ffff, 18'd1, 18'h1ffff, 18'd0};
        end
        5: begin
          vals = '{18'(-10240), 18'd0, 18'd60000, 18'd40000, 18'd2560, 18'd0, 18'd0, 18'd0};
        end
        default: begin
          vals[REG_THRESHOLD] = pick_db(18'h20000, 18'h1ffff);
          vals[REG_RATIO] = CFG_W'($urandom_range(0, 9) == 0 ? $urandom_range(16384, 65535)
                                                             : $urandom_range(0, 16383));
          vals[REG_ATTACK] = CFG_W'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535));
          vals[REG_RELEASE] = CFG_W'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535));
          vals[REG_KNEE_WIDTH] = CFG_W'($urandom_range(0, 4) == 0 ? $urandom_range(0, 131071)
                                                                  : $urandom_range(0, 5000));
          vals[REG_KNEE_OFF] = CFG_W'($urandom_range(0, 5) == 0);
          vals[REG_PREGAIN] = $urandom_range(0, 4) == 0 ? pick_db(18'h20000, 18'h1ffff)
                                                        : CFG_W'($signed($urandom_range(0, 8000)) - 4000);
          vals[REG_POSTGAIN] = $urandom_range(0, 4) == 0 ? pick_db(18'h20000, 18'h1ffff)
                                                         : CFG_W'($signed($urandom_range(0, 8000)) - 4000);
        end
      endcase
      write_regs(vals);
      calm = (ph % 4 == 3);
      ch0 = {};
      ch1 = {};
      if (ph < 5) begin
        ch0 = {24'sd0, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sd1, -24'sd1, 24'sd1, 24'sd4096};
        ch1 = {24'sd0, 24'sh7fffff, 24'sh800000, 24'sh800000, 24'sd0, 24'sd0, -24'sd1, -24'sd4095};
      end
      for (int i = 0; i < 92; i++) begin
        ch0.push_back(pick_sample());
        ch1.push_back($urandom_range(0, 7) == 0 ? -ch0[$] : pick_sample());
      end
      send_frames(ch0, ch1);
    end

    while (sb.exp_ch0_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d frames sent over 13 register settings, %0d matched", n_sent, sb.n_ok);
    $display("bypass %0d, silent mean %0d, saturated %0d", sb.n_bypass, sb.n_silent, sb.n_sat);
    if (sb.n_err == 0 && sb.exp_ch0_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
